// File: hw/rtl/fft_pkg.sv
// Shared types and constants for the five-tuple flow table tracker.
// Used by fft_flow_mem, fft_divider and flow_table_tracker; depends on nothing.
package fft_pkg;

  // Field widths of the packet and result beats.
  localparam int unsigned PROTO_W  = 2;
  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned PORT_W   = 16;
  localparam int unsigned FLEN_W   = 12;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned PKTS_W   = 32;
  localparam int unsigned BYTES_W  = 48;
  localparam int unsigned BW_W     = 42;
  localparam int unsigned INDEX_W  = 8;

  // Divider widths: dividend is bytes * 8, divisor is duration * 1000.
  localparam int unsigned NUM_W    = BYTES_W + 3;
  localparam int unsigned DEN_W    = TIME_W + 10;
  localparam int unsigned DIV_CNT_W = $clog2(NUM_W);

  // Five-tuple key as held in the key memory.
  typedef struct packed {
    logic [ADDR_W-1:0]  source_address;
    logic [ADDR_W-1:0]  destination_address;
    logic [PORT_W-1:0]  source_port;
    logic [PORT_W-1:0]  destination_port;
    logic [PROTO_W-1:0] protocol;
  } fft_key_t;

  // Per-flow counters and times as held in the statistics memory.
  typedef struct packed {
    logic [PKTS_W-1:0]  packets;
    logic [BYTES_W-1:0] bytes;
    logic [TIME_W-1:0]  first_time;
    logic [TIME_W-1:0]  last_time;
  } fft_stats_t;

  // Result status codes.
  typedef enum logic [1:0] {
    STATUS_UPDATED = 2'd0,
    STATUS_ADDED   = 2'd1,
    STATUS_DROPPED = 2'd2
  } fft_status_e;

  // Control sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_UPDATE,
    ST_NEW,
    ST_DROP,
    ST_DIVIDE,
    ST_OUTPUT
  } fft_state_e;

  // Divider status seen by the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } fft_div_status_t;

endpackage

// File: hw/rtl/flow_table_tracker.sv
// Five-tuple flow table tracker: top level with the search and update sequencer.
// Depends on fft_pkg, fft_flow_mem and fft_divider.
//
// Usage: each packet arrives as one beat on the s_ channel and produces exactly
// one result beat on the m_ channel. s_tuser carries the protocol; s_tdata the
// addresses, ports, frame length and time stamp. m_tuser carries the status
// (updated, added or dropped); m_tdata the slot, counters, duration, bandwidth.
// The table is searched one slot per cycle in insertion order, with a
// registered read of the key and statistics memories at the same address.
// A packet that hits a slot waits for the bit-serial bandwidth divider when
// its duration is nonzero. A miss or a drop scans every filled slot.
// One packet is processed at a time, and the next beat can be taken once
// the sequencer is back in idle after a result is loaded. s_tready is
// high whenever the sequencer is idle and reset is released, even while a
// finished result still waits in the output register. When the receiver stalls,
// the result beat holds and the next packet waits before its result is loaded.
// Reset empties the table (no clearing pass is needed: only filled slots are
// ever read) and drops any result in flight.
module flow_table_tracker #(
  parameter int unsigned FLOW_ENTRIES = 256
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // s_tdata, low bit up: source_address[31:0], destination_address[63:32],
  // source_port[79:64], destination_port[95:80], frame_length[107:96],
  // now_seconds[139:108], zero fill[143:140].
  input  logic [143:0] s_tdata,
  // s_tuser: protocol[1:0].
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // m_tdata, low bit up: entry_index[7:0], packet_total[39:8],
  // byte_total[87:40], duration_seconds[119:88], rate_kbps[161:120],
  // zero fill[167:162].
  output logic [167:0] m_tdata,
  // m_tuser: status[1:0].
  output logic [1:0]   m_tuser
);
  import fft_pkg::*;

  localparam int unsigned IDX_W = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(FLOW_ENTRIES + 1);

  fft_state_e       state;
  fft_state_e       state_next;

  // Packet held for the whole search.
  fft_key_t         in_key;
  logic [FLEN_W-1:0] in_flen;
  logic [TIME_W-1:0] in_now;

  logic [CNT_W-1:0] flows_in_use;
  logic [CNT_W-1:0] scan_idx;
  logic             cmp_valid;
  logic [IDX_W-1:0] cmp_idx;
  logic [IDX_W-1:0] hit_idx;
  fft_stats_t       hit_stats;
  logic             hit;
  logic             table_full;

  // Result being assembled.
  fft_status_e       res_status;
  logic [INDEX_W-1:0] res_index;
  logic [PKTS_W-1:0]  res_packets;
  logic [BYTES_W-1:0] res_bytes;
  logic [TIME_W-1:0]  res_dur;
  logic [BW_W-1:0]    res_bw;

  // Memory and divider hookup.
  logic             rd_en;
  logic [IDX_W-1:0] wr_addr;
  logic             key_we;
  logic             stat_we;
  fft_key_t         key_rdata;
  fft_stats_t       stat_rdata;
  fft_stats_t       stat_wdata;
  logic             div_start;
  logic [BW_W-1:0]  div_quot;
  fft_div_status_t  div_stat;

  // Update arithmetic for a hit.
  logic [PKTS_W-1:0]  upd_packets;
  logic [BYTES_W:0]   upd_sum;
  logic [BYTES_W-1:0] upd_bytes;
  logic [TIME_W-1:0]  upd_dur;
  logic               out_free;
  logic [IDX_W+INDEX_W-1:0] hit_idx_wide;
  logic [IDX_W+INDEX_W-1:0] new_idx_wide;

  assign hit        = cmp_valid && (key_rdata == in_key);
  assign table_full = (flows_in_use >= CNT_W'(FLOW_ENTRIES));
  assign out_free   = !m_tvalid || m_tready;

  assign upd_packets = (hit_stats.packets == '1) ? hit_stats.packets
                                                 : hit_stats.packets + 1'b1;
  assign upd_sum     = {1'b0, hit_stats.bytes} + {{(BYTES_W + 1 - FLEN_W){1'b0}}, in_flen};
  assign upd_bytes   = upd_sum[BYTES_W] ? {BYTES_W{1'b1}} : upd_sum[BYTES_W-1:0];
  assign upd_dur     = (in_now >= hit_stats.first_time) ? in_now - hit_stats.first_time
                                                        : '0;

  // The reported slot is the low byte of the table index.
  assign hit_idx_wide = {{INDEX_W{1'b0}}, hit_idx};
  assign new_idx_wide = {{INDEX_W{1'b0}}, flows_in_use[IDX_W-1:0]};

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (hit) begin
          state_next = ST_UPDATE;
        end else if (scan_idx == flows_in_use) begin
          state_next = table_full ? ST_DROP : ST_NEW;
        end
      end
      ST_UPDATE: begin
        state_next = (upd_dur != '0) ? ST_DIVIDE : ST_OUTPUT;
      end
      ST_NEW:    state_next = ST_OUTPUT;
      ST_DROP:   state_next = ST_OUTPUT;
      ST_DIVIDE: begin
        if (div_stat.done) state_next = ST_OUTPUT;
      end
      ST_OUTPUT: begin
        if (out_free) state_next = ST_IDLE;
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    s_tready   = 1'b0;
    rd_en      = 1'b0;
    key_we     = 1'b0;
    stat_we    = 1'b0;
    div_start  = 1'b0;
    wr_addr    = hit_idx;
    stat_wdata = '{packets: upd_packets, bytes: upd_bytes,
                   first_time: hit_stats.first_time, last_time: in_now};
    unique case (state)
      ST_IDLE:   s_tready = !rst;
      ST_SEARCH: rd_en = !hit && (scan_idx < flows_in_use);
      ST_UPDATE: begin
        stat_we   = 1'b1;
        div_start = (upd_dur != '0);
      end
      ST_NEW: begin
        key_we     = 1'b1;
        stat_we    = 1'b1;
        wr_addr    = flows_in_use[IDX_W-1:0];
        stat_wdata = '{packets: PKTS_W'(1),
                       bytes: {{(BYTES_W - FLEN_W){1'b0}}, in_flen},
                       first_time: in_now, last_time: in_now};
      end
      ST_DROP, ST_DIVIDE, ST_OUTPUT: ;
      default: ;
    endcase
  end

  // State and control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      flows_in_use <= '0;
      cmp_valid    <= 1'b0;
      m_tvalid     <= 1'b0;
    end else begin
      state     <= state_next;
      cmp_valid <= rd_en;
      if (state == ST_NEW) begin
        flows_in_use <= flows_in_use + 1'b1;
      end
      if (state == ST_OUTPUT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Packet capture, scan pointer and result assembly.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        in_key   <= '{source_address:      s_tdata[31:0],
                      destination_address: s_tdata[63:32],
                      source_port:         s_tdata[79:64],
                      destination_port:    s_tdata[95:80],
                      protocol:            s_tuser};
        in_flen  <= s_tdata[107:96];
        in_now   <= s_tdata[139:108];
        scan_idx <= '0;
      end
      ST_SEARCH: begin
        if (rd_en) begin
          scan_idx <= scan_idx + 1'b1;
          cmp_idx  <= scan_idx[IDX_W-1:0];
        end
        if (hit) begin
          hit_idx   <= cmp_idx;
          hit_stats <= stat_rdata;
        end
      end
      ST_UPDATE: begin
        res_status  <= STATUS_UPDATED;
        res_index   <= hit_idx_wide[INDEX_W-1:0];
        res_packets <= upd_packets;
        res_bytes   <= upd_bytes;
        res_dur     <= upd_dur;
        res_bw      <= '0;
      end
      ST_NEW: begin
        res_status  <= STATUS_ADDED;
        res_index   <= new_idx_wide[INDEX_W-1:0];
        res_packets <= PKTS_W'(1);
        res_bytes   <= {{(BYTES_W - FLEN_W){1'b0}}, in_flen};
        res_dur     <= '0;
        res_bw      <= '0;
      end
      ST_DROP: begin
        res_status  <= STATUS_DROPPED;
        res_index   <= '0;
        res_packets <= '0;
        res_bytes   <= '0;
        res_dur     <= '0;
        res_bw      <= '0;
      end
      ST_DIVIDE: begin
        if (div_stat.done) res_bw <= div_quot;
      end
      ST_OUTPUT: begin
        if (out_free) begin
          m_tuser <= res_status;
          m_tdata <= {6'b0, res_bw, res_dur, res_bytes, res_packets, res_index};
        end
      end
      default: ;
    endcase
  end

  fft_flow_mem #(
    .ENTRIES (FLOW_ENTRIES),
    .IDX_W   (IDX_W)
  ) u_mem (
    .clk        (clk),
    .rd_en      (rd_en),
    .rd_addr    (scan_idx[IDX_W-1:0]),
    .key_rdata  (key_rdata),
    .stat_rdata (stat_rdata),
    .key_we     (key_we),
    .stat_we    (stat_we),
    .wr_addr    (wr_addr),
    .key_wdata  (in_key),
    .stat_wdata (stat_wdata)
  );

  fft_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .bytes    (upd_bytes),
    .duration (upd_dur),
    .quotient (div_quot),
    .status   (div_stat)
  );

  // The fill count never passes the table size.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    flows_in_use <= CNT_W'(FLOW_ENTRIES))
    else $error("flow count exceeds table size");

  // A key is written only when a flow is added, and never into a full table.
  a_key_write: assert property (@(posedge clk) disable iff (rst)
    key_we |-> (state == ST_NEW) && !table_full)
    else $error("key memory written outside a flow add");

  // An accepted packet always starts a search on the next cycle.
  a_accept_search: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == ST_SEARCH))
    else $error("accepted packet did not start a search");

  // The divider only finishes while the sequencer waits for it.
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> (state == ST_DIVIDE) && !div_stat.busy)
    else $error("divider finished outside the divide state");

endmodule

// File: hw/rtl/fft_flow_mem.sv
// Flow table storage: a key memory and a statistics memory sharing one read address.
// Depends on fft_pkg for the key and statistics entry types.
module fft_flow_mem #(
  parameter int unsigned ENTRIES = 256,
  parameter int unsigned IDX_W   = 8
) (
  input  logic                clk,
  input  logic                rd_en,
  input  logic [IDX_W-1:0]    rd_addr,
  output fft_pkg::fft_key_t   key_rdata,
  output fft_pkg::fft_stats_t stat_rdata,
  input  logic                key_we,
  input  logic                stat_we,
  input  logic [IDX_W-1:0]    wr_addr,
  input  fft_pkg::fft_key_t   key_wdata,
  input  fft_pkg::fft_stats_t stat_wdata
);
  import fft_pkg::*;

  fft_key_t   key_mem  [ENTRIES];
  fft_stats_t stat_mem [ENTRIES];

  // Registered read of both memories at the same slot.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      key_rdata  <= key_mem[rd_addr];
      stat_rdata <= stat_mem[rd_addr];
    end
  end

  // Independent write enables; the key is written only when a flow is added.
  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[wr_addr] <= key_wdata;
    end
    if (stat_we) begin
      stat_mem[wr_addr] <= stat_wdata;
    end
  end

endmodule

// File: hw/rtl/fft_divider.sv
// Bit-serial restoring divider for the bandwidth: floor(bytes * 8 / (duration * 1000)).
// Depends on fft_pkg for widths and the status struct.
module fft_divider (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [fft_pkg::BYTES_W-1:0] bytes,
  input  logic [fft_pkg::TIME_W-1:0]  duration,
  output logic [fft_pkg::BW_W-1:0]    quotient,
  output fft_pkg::fft_div_status_t    status
);
  import fft_pkg::*;

  logic [NUM_W-1:0]     numer;
  logic [DEN_W-1:0]     denom;
  logic [DEN_W-1:0]     rem;
  logic [NUM_W-1:0]     quot;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic                 done;
  logic [DEN_W:0]       rem_shift;
  logic [DEN_W:0]       diff;
  logic                 fits;
  logic [DEN_W-1:0]     denom_load;

  // Duration times 1000 as 1024 - 16 - 8 shifted copies.
  assign denom_load = {duration, 10'b0}
                    - {6'b0, duration, 4'b0}
                    - {7'b0, duration, 3'b0};

  // One quotient bit per cycle: shift in the next dividend bit and trial-subtract.
  assign rem_shift = {rem, numer[NUM_W-1]};
  assign diff      = rem_shift - {1'b0, denom};
  assign fits      = ~diff[DEN_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(NUM_W - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  // Datapath registers need no reset.
  always_ff @(posedge clk) begin
    if (start) begin
      numer <= {bytes, 3'b000};
      denom <= denom_load;
      rem   <= '0;
      quot  <= '0;
    end else if (busy) begin
      numer <= {numer[NUM_W-2:0], 1'b0};
      rem   <= fits ? diff[DEN_W-1:0] : rem_shift[DEN_W-1:0];
      quot  <= {quot[NUM_W-2:0], fits};
    end
  end

  assign quotient    = quot[BW_W-1:0];
  assign status.busy = busy;
  assign status.done = done;

endmodule

// File: tb/sv/tb.sv
// Self-checking testbench for flow_table_tracker: packet beats in, one result beat out per packet.
// A directed table runs first, then random traffic that fills the flow table and overflows it.
// Depends on fft_pkg and the flow_table_tracker RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fft_pkg::*;

  localparam int unsigned TABLE_SLOTS  = 256;
  localparam int unsigned RANDOM_BEATS = 280;
  localparam int unsigned STALL_LIMIT  = 5000;
  localparam int unsigned KEY_W        = $bits(fft_key_t);
  localparam logic [BYTES_W-1:0] BYTES_FULL = '1;
  localparam logic [PKTS_W-1:0]  PKTS_FULL  = '1;

  // One packet as the sender sees it.
  typedef struct {
    fft_key_t            key;
    logic [FLEN_W-1:0]   frame_length;
    logic [TIME_W-1:0]   now_seconds;
  } packet_t;

  // One result beat, field by field.
  typedef struct {
    fft_status_e         status;
    logic [INDEX_W-1:0]  entry_index;
    logic [PKTS_W-1:0]   packet_total;
    logic [BYTES_W-1:0]  byte_total;
    logic [TIME_W-1:0]   duration_seconds;
    logic [BW_W-1:0]     rate_kbps;
  } result_t;

  // A directed row; fixed_result holds a hand-written answer when has_fixed is set.
  typedef struct {
    packet_t             pkt;
    bit                  has_fixed;
    result_t             fixed_result;
  } directed_row_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [143:0] s_tdata = '0;
  logic [1:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [167:0] m_tdata;
  logic [1:0]   m_tuser;

  // Flow table as the testbench tracks it.
  fft_key_t           seen_key   [TABLE_SLOTS];
  logic [PKTS_W-1:0]  seen_pkts  [TABLE_SLOTS];
  logic [BYTES_W-1:0] seen_bytes [TABLE_SLOTS];
  logic [TIME_W-1:0]  seen_first [TABLE_SLOTS];
  int unsigned        seen_count = 0;

  result_t       pending_results[$];
  directed_row_t directed_rows[$];
  result_t       arrived;
  result_t       oldest;
  result_t       no_result;
  int unsigned   mismatches = 0;
  int unsigned   send_idle_pct = 0;
  int unsigned   recv_stall_pct = 0;
  int unsigned   quiet_cycles = 0;
  logic [TIME_W-1:0] clock_base = 32'd1000;

  flow_table_tracker #(.FLOW_ENTRIES(TABLE_SLOTS)) DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #10 clk = ~clk;

  // Look the packet up in insertion order, update, append or drop, and return the expected beat.
  function automatic result_t account_packet(input packet_t p);
    result_t     r;
    logic [BYTES_W:0] sum;
    logic [63:0] num;
    logic [63:0] den;
    int          slot;
    slot = -1;
    for (int i = 0; i < seen_count; i++) begin
      if (slot < 0 && seen_key[i] == p.key) slot = i;
    end
    r.status = STATUS_DROPPED;
    r.entry_index = '0;
    r.packet_total = '0;
    r.byte_total = '0;
    r.duration_seconds = '0;
    r.rate_kbps = '0;
    if (slot >= 0) begin
      if (seen_pkts[slot] != PKTS_FULL) seen_pkts[slot] = seen_pkts[slot] + 1'b1;
      sum = {1'b0, seen_bytes[slot]} + (BYTES_W + 1)'(p.frame_length);
      seen_bytes[slot] = sum[BYTES_W] ? BYTES_FULL : sum[BYTES_W-1:0];
      r.status = STATUS_UPDATED;
      r.entry_index = slot[INDEX_W-1:0];
      r.packet_total = seen_pkts[slot];
      r.byte_total = seen_bytes[slot];
      // Time running backwards past the first sighting clamps the duration to zero.
      if (p.now_seconds >= seen_first[slot])
        r.duration_seconds = p.now_seconds - seen_first[slot];
      if (r.duration_seconds != 0) begin
        num = 64'(seen_bytes[slot]) * 64'd8;
        den = 64'(r.duration_seconds) * 64'd1000;
        r.rate_kbps = BW_W'(num / den);
      end
    end else if (seen_count < TABLE_SLOTS) begin
      seen_key[seen_count] = p.key;
      seen_pkts[seen_count] = 1;
      seen_bytes[seen_count] = BYTES_W'(p.frame_length);
      seen_first[seen_count] = p.now_seconds;
      r.status = STATUS_ADDED;
      r.entry_index = INDEX_W'(seen_count);
      r.packet_total = 1;
      r.byte_total = BYTES_W'(p.frame_length);
      seen_count++;
    end
    return r;
  endfunction

  // Random traffic: mostly repeats of known flows, some near misses and fresh flows.
  function automatic packet_t random_packet();
    packet_t     p;
    int unsigned pick;
    int unsigned slot;
    pick = $urandom_range(99);
    if (seen_count != 0 && pick < 60) begin
      if (pick < 30 && seen_count > 8) slot = seen_count - 1 - $urandom_range(7);
      else slot = $urandom_range(seen_count - 1);
      p.key = seen_key[slot];
    end else if (seen_count != 0 && pick < 75) begin
      p.key = seen_key[$urandom_range(seen_count - 1)];
      p.key = p.key ^ (KEY_W'(1) << $urandom_range(KEY_W - 1));
    end else begin
      p.key.source_address = $urandom();
      p.key.destination_address = $urandom();
      p.key.source_port = PORT_W'($urandom_range(16'hFFFF));
      p.key.destination_port = PORT_W'($urandom_range(16'hFFFF));
      p.key.protocol = PROTO_W'($urandom_range(3));
    end
    case ($urandom_range(9))
      0: p.frame_length = $urandom_range(1) ? 12'hFFF : 12'h000;
      1: p.frame_length = FLEN_W'($urandom_range(12'hFFF));
      default: p.frame_length = FLEN_W'($urandom_range(2048, 1));
    endcase
    // Time mostly creeps forward; now and then it jumps or steps back.
    pick = $urandom_range(99);
    if (pick < 2) clock_base = clock_base + $urandom();
    else clock_base = clock_base + $urandom_range(2);
    if (pick >= 2 && pick < 5) p.now_seconds = clock_base - $urandom_range(1000, 1);
    else if (pick >= 5 && pick < 7) p.now_seconds = $urandom();
    else p.now_seconds = clock_base;
    return p;
  endfunction

  function automatic void add_row(input logic [1:0] proto, input logic [31:0] src,
                                  input logic [31:0] dst, input logic [15:0] sport,
                                  input logic [15:0] dport, input logic [11:0] flen,
                                  input logic [31:0] now, input bit fixed,
                                  input fft_status_e status, input logic [7:0] idx,
                                  input logic [31:0] pkts, input logic [47:0] bytes,
                                  input logic [31:0] dur, input logic [41:0] bw);
    directed_row_t row;
    row.pkt.key.protocol = proto;
    row.pkt.key.source_address = src;
    row.pkt.key.destination_address = dst;
    row.pkt.key.source_port = sport;
    row.pkt.key.destination_port = dport;
    row.pkt.frame_length = flen;
    row.pkt.now_seconds = now;
    row.has_fixed = fixed;
    row.fixed_result.status = status;
    row.fixed_result.entry_index = idx;
    row.fixed_result.packet_total = pkts;
    row.fixed_result.byte_total = bytes;
    row.fixed_result.duration_seconds = dur;
    row.fixed_result.rate_kbps = bw;
    directed_rows.push_back(row);
  endfunction

  // Present one packet beat, wait for it to be taken, then queue its expected result.
  task automatic send_packet(input packet_t p, input bit fixed, input result_t fixed_result);
    int unsigned gaps;
    result_t     predicted;
    gaps = 0;
    while ($urandom_range(99) < send_idle_pct) gaps++;
    if (gaps != 0) begin
      s_tvalid <= 1'b0;
      repeat (gaps) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= p.key.protocol;
    s_tdata <= {4'b0, p.now_seconds, p.frame_length, p.key.destination_port,
                p.key.source_port, p.key.destination_address, p.key.source_address};
    do @(posedge clk); while (!s_tready);
    predicted = account_packet(p);
    pending_results.push_back(fixed ? fixed_result : predicted);
  endtask

  function automatic void check_field(input string label, input logic [63:0] want_v,
                                      input logic [63:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, label, want_v, got_v);
      mismatches++;
    end
  endfunction

  // Result side: check each accepted beat against the oldest expectation, then pick a stall.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      arrived.status = fft_status_e'(m_tuser);
      arrived.entry_index = m_tdata[7:0];
      arrived.packet_total = m_tdata[39:8];
      arrived.byte_total = m_tdata[87:40];
      arrived.duration_seconds = m_tdata[119:88];
      arrived.rate_kbps = m_tdata[161:120];
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual status %h index %h",
                 $time, m_tuser, m_tdata[7:0]);
        mismatches++;
      end else begin
        oldest = pending_results.pop_front();
        check_field("status", 64'(oldest.status), 64'(arrived.status));
        check_field("entry_index", 64'(oldest.entry_index), 64'(arrived.entry_index));
        check_field("packet_total", 64'(oldest.packet_total), 64'(arrived.packet_total));
        check_field("byte_total", 64'(oldest.byte_total), 64'(arrived.byte_total));
        check_field("duration_seconds", 64'(oldest.duration_seconds),
                    64'(arrived.duration_seconds));
        check_field("rate_kbps", 64'(oldest.rate_kbps),
                    64'(arrived.rate_kbps));
      end
    end
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog: end the run if no beat moves on either side for too long.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Main sequence: reset, directed table, random traffic under changing idle patterns.
  initial begin
    int unsigned send_pct [5];
    int unsigned recv_pct [5];
    send_pct = '{0, 78, 0, 31, 0};
    recv_pct = '{0, 0, 78, 31, 0};
    no_result.status = STATUS_UPDATED;
    no_result.entry_index = '0;
    no_result.packet_total = '0;
    no_result.byte_total = '0;
    no_result.duration_seconds = '0;
    no_result.rate_kbps = '0;

    // New flows at the field extremes, zero length, a flow with zero ports.
    add_row(2'd0, 32'h0, 32'h0, 16'h0, 16'h0, 12'd1, 32'd0,
            1, STATUS_ADDED, 8'd0, 32'd1, 48'd1, 32'd0, 42'd0);
    add_row(2'd3, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF, 12'hFFF, 32'd0,
            1, STATUS_ADDED, 8'd1, 32'd1, 48'd4095, 32'd0, 42'd0);
    add_row(2'd1, 32'h0A000001, 32'h0A000002, 16'd1234, 16'd80, 12'd0, 32'd10,
            1, STATUS_ADDED, 8'd2, 32'd1, 48'd0, 32'd0, 42'd0);
    add_row(2'd2, 32'hC0A80101, 32'h08080808, 16'd0, 16'd0, 12'd64, 32'd10,
            1, STATUS_ADDED, 8'd3, 32'd1, 48'd64, 32'd0, 42'd0);
    // Hits: one-second duration gives a nonzero bandwidth.
    add_row(2'd3, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF, 12'hFFF, 32'd1,
            1, STATUS_UPDATED, 8'd1, 32'd2, 48'd8190, 32'd1, 42'd65);
    add_row(2'd1, 32'h0A000001, 32'h0A000002, 16'd1234, 16'd80, 12'd0, 32'd12,
            0, STATUS_UPDATED, 8'd0, 32'd0, 48'd0, 32'd0, 42'd0);
    // Same addresses and ports under another protocol is a different flow.
    add_row(2'd0, 32'h0A000001, 32'h0A000002, 16'd1234, 16'd80, 12'd1500, 32'd12,
            0, STATUS_UPDATED, 8'd0, 32'd0, 48'd0, 32'd0, 42'd0);
    // Time earlier than the first sighting.
    add_row(2'd2, 32'hC0A80101, 32'h08080808, 16'd0, 16'd0, 12'd100, 32'd5,
            1, STATUS_UPDATED, 8'd3, 32'd2, 48'd164, 32'd0, 42'd0);
    add_row(2'd0, 32'h0, 32'h0, 16'h0, 16'h0, 12'd2048, 32'hFFFFFFFF,
            0, STATUS_UPDATED, 8'd0, 32'd0, 48'd0, 32'd0, 42'd0);
    // Swapped addresses and swapped ports are new flows.
    add_row(2'd1, 32'h0A000002, 32'h0A000001, 16'd1234, 16'd80, 12'd700, 32'd13,
            0, STATUS_UPDATED, 8'd0, 32'd0, 48'd0, 32'd0, 42'd0);
    add_row(2'd1, 32'h0A000001, 32'h0A000002, 16'd80, 16'd1234, 12'd900, 32'd13,
            0, STATUS_UPDATED, 8'd0, 32'd0, 48'd0, 32'd0, 42'd0);
    add_row(2'd1, 32'h0A000001, 32'h0A000002, 16'd1234, 16'd80, 12'd2048, 32'h80000000,
            0, STATUS_UPDATED, 8'd0, 32'd0, 48'd0, 32'd0, 42'd0);
    add_row(2'd3, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF, 12'hFFF, 32'hFFFFFFFF,
            0, STATUS_UPDATED, 8'd0, 32'd0, 48'd0, 32'd0, 42'd0);
    add_row(2'd0, 32'h0A000001, 32'h0A000002, 16'd1234, 16'd80, 12'hFFF, 32'd14,
            0, STATUS_UPDATED, 8'd0, 32'd0, 48'd0, 32'd0, 42'd0);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_packet(directed_rows[i].pkt, directed_rows[i].has_fixed,
                  directed_rows[i].fixed_result);

    for (int ph = 0; ph < 5; ph++) begin
      send_idle_pct = send_pct[ph];
      recv_stall_pct = recv_pct[ph];
      repeat (RANDOM_BEATS) send_packet(random_packet(), 0, no_result);
    end
    s_tvalid <= 1'b0;

    // Drain, then allow a full search time for anything stray to show up.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TABLE_SLOTS + 64) @(posedge clk);
    if (mismatches == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
